// ===== hw/rtl/ssbr_pkg.sv =====
`default_nettype none
package ssbr_pkg;

  localparam int BYTE_W   = 8;
  localparam int STORE_AW = 11;
  localparam int ID_AW    = 6;

  localparam int BLOCK_BYTES_DEF = 128;
  localparam int BLOCK_COUNT_DEF = 16;
  localparam int ID_LENGTH_DEF   = 28;

  localparam logic [BYTE_W-1:0] OP_BLOCK_NEXT  = 8'hAC;
  localparam logic [BYTE_W-1:0] OP_BLOCK_START = 8'hBC;
  localparam logic [BYTE_W-1:0] OP_ID_NEXT     = 8'hAE;
  localparam logic [BYTE_W-1:0] OP_ID_RESTART  = 8'hBE;
  localparam logic [BYTE_W-1:0] OP_SAMPLE_ON   = 8'hAD;
  localparam logic [BYTE_W-1:0] OP_SAMPLE_OFF  = 8'hBD;
  localparam logic [BYTE_W-1:0] REPLY_UNKNOWN  = 8'h01;

  localparam logic CMD_RX    = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Single-port store access
  typedef struct packed {
    logic                en;
    logic                we;
    logic [STORE_AW-1:0] addr;
    logic [BYTE_W-1:0]   wdata;
  } mem_req_t;

  // Reply produced by one accepted beat
  typedef struct packed {
    logic              valid;
    logic              use_mem;
    logic [BYTE_W-1:0] tx;
    logic              flag;
  } reply_t;

  // Identification text; positions past the stored bytes read as zero
  function automatic logic [BYTE_W-1:0] id_byte(input logic [ID_AW-1:0] pos);
    logic [BYTE_W-1:0] b;
    case (pos)
      6'd0:    b = 8'h48;
      6'd1:    b = 8'h65;
      6'd2:    b = 8'h6C;
      6'd3:    b = 8'h6C;
      6'd4:    b = 8'h6F;
      6'd5:    b = 8'h2C;
      6'd6:    b = 8'h20;
      6'd7:    b = 8'h74;
      6'd8:    b = 8'h68;
      6'd9:    b = 8'h69;
      6'd10:   b = 8'h73;
      6'd11:   b = 8'h20;
      6'd12:   b = 8'h69;
      6'd13:   b = 8'h73;
      6'd14:   b = 8'h20;
      6'd15:   b = 8'h50;
      6'd16:   b = 8'h61;
      6'd17:   b = 8'h74;
      6'd18:   b = 8'h68;
      6'd19:   b = 8'h4D;
      6'd20:   b = 8'h65;
      6'd21:   b = 8'h54;
      6'd22:   b = 8'h20;
      6'd23:   b = 8'h52;
      6'd24:   b = 8'h65;
      6'd25:   b = 8'h76;
      6'd26:   b = 8'h42;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ssbr_if.sv =====
`default_nettype none
interface ssbr_in_if import ssbr_pkg::*; ;
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [BYTE_W-1:0]   rx_byte;
  logic [STORE_AW-1:0] write_addr;
  logic [BYTE_W-1:0]   write_data;

  modport source (output valid, cmd, rx_byte, write_addr, write_data, input ready);
  modport sink   (input valid, cmd, rx_byte, write_addr, write_data, output ready);
endinterface

interface ssbr_out_if import ssbr_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] tx_byte;
  logic              sampling_enabled;

  modport source (output valid, tx_byte, sampling_enabled, input ready);
  modport sink   (input valid, tx_byte, sampling_enabled, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ssbr_store.sv =====
`default_nettype none
module ssbr_store import ssbr_pkg::*; (
  input  wire logic              clk,
  input  wire mem_req_t          req,
  output logic [BYTE_W-1:0]      rdata
);

  localparam int DEPTH = 1 << STORE_AW;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata_r <= mem[req.addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hw/rtl/ssbr_ctrl.sv =====
`default_nettype none
module ssbr_ctrl import ssbr_pkg::*; #(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
  parameter int ID_LENGTH   = ID_LENGTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic                cmd,
  input  wire logic [BYTE_W-1:0]   rx_byte,
  input  wire logic [STORE_AW-1:0] write_addr,
  input  wire logic [BYTE_W-1:0]   write_data,
  output mem_req_t                 mem_req,
  output reply_t                   reply
);

  localparam int OFW = $clog2(BLOCK_BYTES);
  localparam int NBW = $clog2(BLOCK_COUNT);
  localparam int IDW = (ID_LENGTH > 1) ? $clog2(ID_LENGTH) : 1;
  localparam logic [OFW-1:0] OFS_LAST    = OFW'(BLOCK_BYTES - 1);
  localparam logic [NBW-1:0] BLK_LAST    = NBW'(BLOCK_COUNT - 1);
  localparam logic [IDW-1:0] ID_LAST     = IDW'(ID_LENGTH - 1);
  localparam logic [IDW-1:0] ID_RESTART  = IDW'(1 % ID_LENGTH);

  logic [NBW-1:0]      next_blk_r, next_blk_nxt;
  logic [STORE_AW-1:0] base_r, base_nxt;
  logic [OFW-1:0]      ofs_r, ofs_nxt;
  logic [IDW-1:0]      id_r, id_nxt;
  logic                flag_r, flag_nxt;

  logic [STORE_AW-1:0] start_base;
  logic [STORE_AW-1:0] next_addr;
  logic                rx_beat;

  assign rx_beat    = accept && (cmd == CMD_RX);
  assign start_base = STORE_AW'(32'(next_blk_r) * BLOCK_BYTES);
  assign next_addr  = STORE_AW'(32'(base_r) + 32'(ofs_r));

  always_comb begin
    next_blk_nxt  = next_blk_r;
    base_nxt      = base_r;
    ofs_nxt       = ofs_r;
    id_nxt        = id_r;
    flag_nxt      = flag_r;
    mem_req.en    = accept && (cmd == CMD_WRITE);
    mem_req.we    = 1'b1;
    mem_req.addr  = write_addr;
    mem_req.wdata = write_data;
    reply.valid   = rx_beat;
    reply.use_mem = 1'b0;
    reply.tx      = REPLY_UNKNOWN;

    if (rx_beat) begin
      case (rx_byte)
        OP_BLOCK_NEXT: begin
          mem_req.en    = 1'b1;
          mem_req.we    = 1'b0;
          mem_req.addr  = next_addr;
          reply.use_mem = 1'b1;
          ofs_nxt       = (ofs_r == OFS_LAST) ? '0 : ofs_r + 1'b1;
        end
        OP_BLOCK_START: begin
          mem_req.en    = 1'b1;
          mem_req.we    = 1'b0;
          mem_req.addr  = start_base;
          reply.use_mem = 1'b1;
          base_nxt      = start_base;
          next_blk_nxt  = (next_blk_r == BLK_LAST) ? '0 : next_blk_r + 1'b1;
          ofs_nxt       = OFW'(1);
        end
        OP_ID_NEXT: begin
          reply.tx = id_byte(ID_AW'(id_r));
          id_nxt   = (id_r == ID_LAST) ? '0 : id_r + 1'b1;
        end
        OP_ID_RESTART: begin
          reply.tx = id_byte('0);
          id_nxt   = ID_RESTART;
        end
        OP_SAMPLE_ON: begin
          reply.tx = OP_SAMPLE_ON;
          flag_nxt = 1'b1;
        end
        OP_SAMPLE_OFF: begin
          reply.tx = OP_SAMPLE_OFF;
          flag_nxt = 1'b0;
        end
        default: begin
          reply.tx = REPLY_UNKNOWN;
        end
      endcase
    end
    reply.flag = flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_blk_r <= '0;
      base_r     <= '0;
      ofs_r      <= '0;
      id_r       <= '0;
      flag_r     <= 1'b0;
    end else begin
      next_blk_r <= next_blk_nxt;
      base_r     <= base_nxt;
      ofs_r      <= ofs_nxt;
      id_r       <= id_nxt;
      flag_r     <= flag_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/spi_slave_block_reader.sv =====
// Channel  Dir  Payload                                   Beat
// in_ch    in   cmd, rx_byte, write_addr, write_data      valid & ready
// out_ch   out  tx_byte, sampling_enabled                 valid & ready
//
// One beat per cycle is taken while in_ch.ready is high. A received byte's
// reply waits in the pending register beside the synchronous store read,
// then moves into the output register once it is free. A store write beat
// gives no reply. Reset clears the block pointers, ID pointer and sampling
// flag; the store itself is not cleared. A stalled output holds one reply
// plus one pending reply; in_ch.ready drops only while both are occupied.
`default_nettype none
module spi_slave_block_reader import ssbr_pkg::*; #(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
  parameter int ID_LENGTH   = ID_LENGTH_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  ssbr_in_if.sink   in_ch,
  ssbr_out_if.source out_ch
);

  mem_req_t          mem_req;
  reply_t            reply;
  logic [BYTE_W-1:0] rdata;
  logic              accept;
  logic              out_free;

  logic              pend_r, pend_nxt;
  logic              pend_mem_r;
  logic [BYTE_W-1:0] pend_tx_r;
  logic              pend_flag_r;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_tx_r;
  logic              out_flag_r;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !pend_r || out_free;
  assign accept      = in_ch.valid && in_ch.ready;

  ssbr_ctrl #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .BLOCK_COUNT (BLOCK_COUNT),
    .ID_LENGTH   (ID_LENGTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .cmd        (in_ch.cmd),
    .rx_byte    (in_ch.rx_byte),
    .write_addr (in_ch.write_addr),
    .write_data (in_ch.write_data),
    .mem_req    (mem_req),
    .reply      (reply)
  );

  ssbr_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  always_comb begin
    pend_nxt = pend_r;
    if (accept && reply.valid) begin
      pend_nxt = 1'b1;
    end else if (pend_r && out_free) begin
      pend_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (pend_r && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the pending reply until the output register frees up, then load it there
  always_ff @(posedge clk) begin
    if (accept && reply.valid) begin
      pend_mem_r  <= reply.use_mem;
      pend_tx_r   <= reply.tx;
      pend_flag_r <= reply.flag;
    end
    if (pend_r && out_free) begin
      out_tx_r   <= pend_mem_r ? rdata : pend_tx_r;
      out_flag_r <= pend_flag_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.tx_byte          = out_tx_r;
  assign out_ch.sampling_enabled = out_flag_r;

endmodule
`default_nettype wire

// ===== bench/spi_slave_block_reader_tb.sv =====
`timescale 1ns / 100ps
module spi_slave_block_reader_tb;
  import ssbr_pkg::*;

  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int CYCLE_LIMIT = 200000;

  // Identification text as held by the responder, terminating zero included
  localparam logic [BYTE_W-1:0] ID_BYTES [ID_LENGTH_DEF] = '{
    8'h48, 8'h65, 8'h6C, 8'h6C, 8'h6F, 8'h2C, 8'h20, 8'h74,
    8'h68, 8'h69, 8'h73, 8'h20, 8'h69, 8'h73, 8'h20, 8'h50,
    8'h61, 8'h74, 8'h68, 8'h4D, 8'h65, 8'h54, 8'h20, 8'h52,
    8'h65, 8'h76, 8'h42, 8'h00
  };

  typedef struct {
    logic                cmd;
    logic [BYTE_W-1:0]   rx_byte;
    logic [STORE_AW-1:0] write_addr;
    logic [BYTE_W-1:0]   write_data;
  } spi_beat_t;

  typedef struct {
    logic [BYTE_W-1:0] tx_byte;
    logic              sampling;
  } spi_reply_t;

  logic clk;
  logic rst_n;

  ssbr_in_if  in_ch ();
  ssbr_out_if out_ch ();

  spi_slave_block_reader i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow of the responder state
  logic [BYTE_W-1:0] store_img [STORE_DEPTH];
  bit                store_written [STORE_DEPTH];
  int                next_blk;
  int                blk_base;
  int                byte_ofs;
  int                id_ptr;
  logic              sample_flag;

  spi_reply_t pending_replies [$];
  spi_reply_t want;

  int mismatches;
  int beats_sent;
  int cycle_count;
  int sink_hold_left;
  bit src_idle_en;
  bit sink_idle_en;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Work out the reply to one accepted beat and advance the shadow state
  task automatic shadow_respond(input spi_beat_t b);
    logic [BYTE_W-1:0] tx;
    if (b.cmd == CMD_WRITE) begin
      store_img[b.write_addr] = b.write_data;
      store_written[b.write_addr] = 1'b1;
    end else begin
      case (b.rx_byte)
        OP_BLOCK_NEXT: begin
          tx = store_img[(blk_base + byte_ofs) % STORE_DEPTH];
          byte_ofs = (byte_ofs + 1) % BLOCK_BYTES_DEF;
        end
        OP_BLOCK_START: begin
          blk_base = next_blk * BLOCK_BYTES_DEF;
          next_blk = (next_blk + 1) % BLOCK_COUNT_DEF;
          tx = store_img[blk_base % STORE_DEPTH];
          byte_ofs = 1 % BLOCK_BYTES_DEF;
        end
        OP_ID_NEXT: begin
          tx = ID_BYTES[id_ptr];
          id_ptr = (id_ptr + 1 >= ID_LENGTH_DEF) ? 0 : id_ptr + 1;
        end
        OP_ID_RESTART: begin
          tx = ID_BYTES[0];
          id_ptr = (1 >= ID_LENGTH_DEF) ? 0 : 1;
        end
        OP_SAMPLE_ON: begin
          sample_flag = 1'b1;
          tx = OP_SAMPLE_ON;
        end
        OP_SAMPLE_OFF: begin
          sample_flag = 1'b0;
          tx = OP_SAMPLE_OFF;
        end
        default: tx = REPLY_UNKNOWN;
      endcase
      pending_replies.push_back('{tx_byte: tx, sampling: sample_flag});
    end
  endtask

  task automatic send_beat(input spi_beat_t b);
    if (src_idle_en && $urandom_range(0, 99) < 30) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= b.cmd;
    in_ch.rx_byte    <= b.rx_byte;
    in_ch.write_addr <= b.write_addr;
    in_ch.write_data <= b.write_data;
    do @(posedge clk); while (!in_ch.ready);
    shadow_respond(b);
    beats_sent++;
  endtask

  task automatic send_write(input logic [STORE_AW-1:0] addr, input logic [BYTE_W-1:0] data);
    spi_beat_t b;
    b.cmd        = CMD_WRITE;
    b.rx_byte    = BYTE_W'($urandom_range(0, 255));
    b.write_addr = addr;
    b.write_data = data;
    send_beat(b);
  endtask

  // Send a received byte, first filling the entry a store read is about to touch if it was never written
  task automatic send_rx(input logic [BYTE_W-1:0] op);
    spi_beat_t b;
    int        addr;
    addr = -1;
    if (op == OP_BLOCK_NEXT)
      addr = (blk_base + byte_ofs) % STORE_DEPTH;
    else if (op == OP_BLOCK_START)
      addr = (next_blk * BLOCK_BYTES_DEF) % STORE_DEPTH;
    if (addr >= 0 && !store_written[addr])
      send_write(STORE_AW'(addr), BYTE_W'($urandom_range(0, 255)));
    b.cmd        = CMD_RX;
    b.rx_byte    = op;
    b.write_addr = STORE_AW'($urandom_range(0, STORE_DEPTH - 1));
    b.write_data = BYTE_W'($urandom_range(0, 255));
    send_beat(b);
  endtask

  // Hold the sender until every reply has come back
  task automatic drain_replies();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  task automatic run_traffic(input int total_beats);
    int                sel;
    int                n;
    logic [BYTE_W-1:0] noise;
    while (beats_sent < total_beats) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        if ($urandom_range(0, 4) != 0) send_rx(OP_BLOCK_START);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 135) : $urandom_range(0, 12);
        repeat (n) send_rx(OP_BLOCK_NEXT);
      end else if (sel < 45) begin
        if ($urandom_range(0, 1) != 0) send_rx(OP_ID_RESTART);
        repeat ($urandom_range(0, 35)) send_rx(OP_ID_NEXT);
      end else if (sel < 55) begin
        send_rx($urandom_range(0, 1) ? OP_SAMPLE_ON : OP_SAMPLE_OFF);
      end else if (sel < 75) begin
        repeat ($urandom_range(1, 6))
          send_write(STORE_AW'($urandom_range(0, STORE_DEPTH - 1)),
                     BYTE_W'($urandom_range(0, 255)));
      end else if (sel < 97) begin
        repeat ($urandom_range(1, 4)) begin
          noise = BYTE_W'($urandom_range(0, 255));
          send_rx(noise);
        end
      end else begin
        drain_replies();
      end
    end
  endtask

  task automatic test_directed_commands();
    spi_beat_t b;
    send_write(STORE_AW'(0), 8'h00);
    send_write(STORE_AW'(1), 8'hFF);
    send_write(STORE_AW'(STORE_DEPTH - 1), 8'hA5);
    send_write(STORE_AW'(BLOCK_BYTES_DEF), 8'h3C);
    // block-next with no block started reads from base zero
    send_rx(OP_BLOCK_NEXT);
    send_rx(OP_BLOCK_NEXT);
    send_rx(OP_BLOCK_START);
    send_rx(OP_BLOCK_NEXT);
    send_rx(OP_BLOCK_START);
    send_rx(OP_ID_NEXT);
    send_rx(OP_ID_NEXT);
    send_rx(OP_ID_RESTART);
    send_rx(OP_ID_NEXT);
    send_rx(OP_SAMPLE_ON);
    send_rx(OP_SAMPLE_ON);
    send_rx(OP_SAMPLE_OFF);
    send_rx(OP_SAMPLE_ON);
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(REPLY_UNKNOWN);
    // a write beat carrying a command byte must not act on it
    b.cmd        = CMD_WRITE;
    b.rx_byte    = OP_BLOCK_START;
    b.write_addr = STORE_AW'(2);
    b.write_data = 8'h77;
    send_beat(b);
    send_rx(OP_SAMPLE_OFF);
    drain_replies();
  endtask

  // Reach the last block, walk it past the offset wrap, then wrap the block index
  task automatic test_last_block_wrap();
    while (next_blk != BLOCK_COUNT_DEF - 1) send_rx(OP_BLOCK_START);
    send_rx(OP_BLOCK_START);
    repeat (BLOCK_BYTES_DEF + 1) send_rx(OP_BLOCK_NEXT);
    send_rx(OP_BLOCK_START);
    send_rx(OP_BLOCK_NEXT);
    drain_replies();
  endtask

  task automatic test_output_stall();
    src_idle_en    = 1'b0;
    sink_hold_left = 150;
    run_traffic(beats_sent + 40);
    drain_replies();
    src_idle_en = 1'b1;
  endtask

  task automatic test_back_to_back();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    run_traffic(beats_sent + 300);
    drain_replies();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    run_traffic(1950);
    drain_replies();
  endtask

  // Result side: ready with random gaps, a counted hold-off, or always ready
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_left > 0) begin
        out_ch.ready <= 1'b0;
        sink_hold_left--;
      end else if (sink_idle_en) begin
        out_ch.ready <= ($urandom_range(0, 99) >= 30);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        $display("%0t: reply expected none actual tx_byte %h sampling_enabled %b",
                 $time, out_ch.tx_byte, out_ch.sampling_enabled);
      end else begin
        want = pending_replies.pop_front();
        if (out_ch.tx_byte !== want.tx_byte) begin
          mismatches++;
          $display("%0t: tx_byte expected %h actual %h", $time, want.tx_byte, out_ch.tx_byte);
        end
        if (out_ch.sampling_enabled !== want.sampling) begin
          mismatches++;
          $display("%0t: sampling_enabled expected %b actual %b",
                   $time, want.sampling, out_ch.sampling_enabled);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_RX;
    in_ch.rx_byte    <= '0;
    in_ch.write_addr <= '0;
    in_ch.write_data <= '0;
    mismatches     = 0;
    beats_sent     = 0;
    sink_hold_left = 0;
    src_idle_en    = 1'b1;
    sink_idle_en   = 1'b1;
    next_blk       = 0;
    blk_base       = 0;
    byte_ofs       = 0;
    id_ptr         = 0;
    sample_flag    = 1'b0;
    foreach (store_written[i]) store_written[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_commands();
    test_last_block_wrap();
    test_output_stall();
    test_back_to_back();
    test_random_traffic();

    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ssbr_pkg.sv
hw/rtl/ssbr_if.sv
hw/rtl/ssbr_store.sv
hw/rtl/ssbr_ctrl.sv
hw/rtl/spi_slave_block_reader.sv
bench/spi_slave_block_reader_tb.sv
